>>> hdl/dedup_order_table_core_defines.svh
// ----------------------------------------------------------------------------
// dedup order table assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef DEDUP_ORDER_TABLE_CORE_DEFINES_SVH
`define DEDUP_ORDER_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define DOT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DOT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DOT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DOT_ASSERT_RST(lbl, clk, prop, msg)

`endif

`endif

>>> hdl/dot_pkg.sv
// ----------------------------------------------------------------------------
// dot_pkg
// beat types, result kinds and command codes of the dedup order table
// ----------------------------------------------------------------------------
`default_nettype none

package dot_pkg;

    // input operations
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DEL = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_INSERTED  = 3'd0;
    localparam logic [2:0] KIND_DUPLICATE = 3'd1;
    localparam logic [2:0] KIND_FULL      = 3'd2;
    localparam logic [2:0] KIND_REMOVED   = 3'd3;
    localparam logic [2:0] KIND_NOTHING   = 3'd4;
    localparam logic [2:0] KIND_BAD_INDEX = 3'd5;

    // input beat
    typedef struct packed {
        logic       operation;
        logic [1:0] floor;
        logic [1:0] button;
        logic [3:0] slot_index;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] out_floor;
        logic [1:0] out_button;
        logic       last;
    } t_out_beat;

    // classified command from the front end
    typedef enum logic [2:0] {
        CMD_ADD = 3'b001,
        CMD_DEL = 3'b010,
        CMD_BAD = 3'b100
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [1:0] floor;
        logic [1:0] button;
        logic [3:0] slot_index;
    } t_cmd;

    // one stored order
    typedef struct packed {
        logic [1:0] floor;
        logic [1:0] button;
    } t_entry;

endpackage

`default_nettype wire

>>> hdl/dot_front.sv
// ----------------------------------------------------------------------------
// dot_front
// accepts input beats, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module dot_front #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire dot_pkg::t_in_beat i_item,
    output logic                  o_cmd_valid,
    input  wire logic             i_cmd_ready,
    output dot_pkg::t_cmd         o_cmd
);
    import dot_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       cls;
    logic       push_ok, pop_ok;

    // classify the beat
    always_comb begin
        cls.floor      = i_item.floor;
        cls.button     = i_item.button;
        cls.slot_index = i_item.slot_index;
        if (i_item.operation == OP_ADD) begin
            cls.op = CMD_ADD;
        end else if ({4'b0, i_item.slot_index} >= 8'(TABLE_DEPTH)) begin
            cls.op = CMD_BAD;
        end else begin
            cls.op = CMD_DEL;
        end
    end

    // queue handshake
    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // queue storage and pointers
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dot_resq.sv
// ----------------------------------------------------------------------------
// dot_resq
// two-entry result queue between the engine and the result port
// ----------------------------------------------------------------------------
`default_nettype none

module dot_resq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dot_pkg::t_out_beat i_beat,
    output logic                   o_full,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output dot_pkg::t_out_beat     o_beat
);
    import dot_pkg::*;

    t_out_beat  r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push_ok, pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_beat  = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // storage and pointers
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= i_beat;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> hdl/dot_engine.sv
// ----------------------------------------------------------------------------
// dot_engine
// order table memory and the sequencer that scans it one entry a cycle unless stalled by a full result queue
// ----------------------------------------------------------------------------
`default_nettype none

`include "dedup_order_table_core_defines.svh"

module dot_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire dot_pkg::t_cmd i_cmd,
    output logic               o_res_push,
    output dot_pkg::t_out_beat o_res_beat,
    input  wire logic          i_res_full
);
    import dot_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TGT  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // control and working registers
    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_keep, n_keep;
    logic      r_ev, n_ev;
    logic [AW-1:0] r_ev_idx, n_ev_idx;
    logic      r_hit, n_hit;
    t_cmd      r_cmd, n_cmd;
    logic [1:0] r_tgt, n_tgt;
    t_out_beat r_pend, n_pend;
    t_out_beat r_fin, n_fin;

    // table memory, registered read
    t_entry    r_mem [TABLE_DEPTH];
    t_entry    r_rd;
    logic      rd_en, we;
    logic [AW-1:0] rd_addr, wa;
    t_entry    wd;

    logic [7:0] idx8;
    logic      ev_self, ev_rm, ev_keep, stall;

    assign idx8    = {4'b0, i_cmd.slot_index};
    assign ev_self = ({4'b0, r_cmd.slot_index} == 8'(r_ev_idx));
    assign ev_rm   = r_ev && (r_cmd.op == CMD_DEL) && !ev_self && (r_rd.floor == r_tgt);
    assign ev_keep = r_ev && (r_cmd.op == CMD_DEL) && !ev_self && (r_rd.floor != r_tgt);
    assign stall   = ev_rm && i_res_full;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_keep      = r_keep;
        n_ev        = r_ev;
        n_ev_idx    = r_ev_idx;
        n_hit       = r_hit;
        n_cmd       = r_cmd;
        n_tgt       = r_tgt;
        n_pend      = r_pend;
        n_fin       = r_fin;
        o_cmd_ready = 1'b0;
        o_res_push  = 1'b0;
        o_res_beat  = r_fin;
        rd_en       = 1'b0;
        rd_addr     = '0;
        we          = 1'b0;
        wa          = '0;
        wd          = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_ready = 1'b1;
                    n_cmd       = i_cmd;
                    n_hit       = 1'b0;
                    n_ptr       = '0;
                    n_keep      = '0;
                    n_ev        = 1'b0;
                    case (i_cmd.op)
                        CMD_BAD: begin
                            n_fin   = '{kind: KIND_BAD_INDEX, out_floor: 2'd0,
                                        out_button: 2'd0, last: 1'b1};
                            n_state = S_EMIT;
                        end
                        CMD_DEL: begin
                            if (idx8 >= 8'(r_count)) begin
                                n_fin   = '{kind: KIND_NOTHING, out_floor: 2'd0,
                                            out_button: 2'd0, last: 1'b1};
                                n_state = S_EMIT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = idx8[AW-1:0];
                                n_state = S_TGT;
                            end
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end

            // named entry becomes the first pending removal
            S_TGT: begin
                n_tgt   = r_rd.floor;
                n_pend  = '{kind: KIND_REMOVED, out_floor: r_rd.floor,
                            out_button: r_rd.button, last: 1'b0};
                n_state = S_SCAN;
            end

            // read one entry, evaluate the one held in r_rd from the read before
            S_SCAN: begin
                if (!stall) begin
                    if (r_ev && (r_cmd.op == CMD_ADD) && (r_rd.floor == r_cmd.floor)
                            && (r_rd.button == r_cmd.button)) begin
                        n_hit = 1'b1;
                    end
                    if (ev_rm) begin
                        o_res_push = 1'b1;
                        o_res_beat = r_pend;
                        n_pend     = '{kind: KIND_REMOVED, out_floor: r_rd.floor,
                                       out_button: r_rd.button, last: 1'b0};
                    end
                    if (ev_keep) begin
                        we     = 1'b1;
                        wa     = r_keep[AW-1:0];
                        wd     = r_rd;
                        n_keep = r_keep + CW'(1);
                    end
                    if (r_ptr != r_count) begin
                        rd_en    = 1'b1;
                        rd_addr  = r_ptr[AW-1:0];
                        n_ev     = 1'b1;
                        n_ev_idx = r_ptr[AW-1:0];
                        n_ptr    = r_ptr + CW'(1);
                    end else begin
                        n_ev = 1'b0;
                        if (!r_ev) begin
                            n_state = S_EMIT;
                            if (r_cmd.op == CMD_DEL) begin
                                // compacted table now holds only the kept entries
                                n_count = r_keep;
                                n_fin   = r_pend;
                                n_fin.last = 1'b1;
                            end else begin
                                n_fin.out_floor  = r_cmd.floor;
                                n_fin.out_button = r_cmd.button;
                                n_fin.last       = 1'b1;
                                if (r_hit) begin
                                    n_fin.kind = KIND_DUPLICATE;
                                end else if (r_count == CW'(TABLE_DEPTH)) begin
                                    n_fin.kind = KIND_FULL;
                                end else begin
                                    n_fin.kind = KIND_INSERTED;
                                    we         = 1'b1;
                                    wa         = r_count[AW-1:0];
                                    wd         = '{floor: r_cmd.floor, button: r_cmd.button};
                                    n_count    = r_count + CW'(1);
                                end
                            end
                        end
                    end
                end
            end

            // final beat of the item
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res_beat = r_fin;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_keep  <= '0;
            r_ev    <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_keep  <= n_keep;
            r_ev    <= n_ev;
            r_hit   <= n_hit;
        end
        r_ev_idx <= n_ev_idx;
        r_cmd    <= n_cmd;
        r_tgt    <= n_tgt;
        r_pend   <= n_pend;
        r_fin    <= n_fin;
    end

    // checks
    `DOT_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH), "entry count past depth")
    `DOT_ASSERT(a_push_room, i_clk, i_rst_n, o_res_push |-> !i_res_full, "result push into full queue")
    `DOT_ASSERT(a_keep_behind, i_clk, i_rst_n, r_keep <= r_ptr, "compaction write ahead of scan")
    `DOT_ASSERT(a_ev_in_range, i_clk, i_rst_n, r_ev |-> (CW'(r_ev_idx) < r_count), "scan past last entry")
    `DOT_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && r_count == '0), "reset did not empty table")

endmodule

`default_nettype wire

>>> hdl/dedup_order_table_core.sv
// The table sits in a memory with one read and one write port, and the engine walks it
// one entry per cycle for an add (duplicate search) as well as for a delete (same-floor
// removal and compaction); the walk covers the orders pending when the item leaves the
// input queue. A delete of an empty slot or a bad index skips the walk. Results are taken
// one per cycle from a two-entry output queue, and a delete stalls its scan while it has a
// removal to queue and that queue is full. Two more input items can wait in the input
// queue while one is worked on. Reset empties the table at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// dedup_order_table_core
// arrival-ordered, duplicate-free table of pending elevator call orders
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_order_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire dot_pkg::t_in_beat i_item,
    output logic                   empty,
    input  wire logic              pop,
    output dot_pkg::t_out_beat     o_result
);
    import dot_pkg::*;

    t_cmd      cmd;
    logic      cmd_valid, cmd_ready;
    t_out_beat res_beat;
    logic      res_push, res_full;

    // classify and queue input beats
    dot_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // table and scan engine
    dot_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_push  (res_push),
        .o_res_beat  (res_beat),
        .i_res_full  (res_full)
    );

    // result queue
    dot_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_beat  (res_beat),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_beat  (o_result)
    );

endmodule

`default_nettype wire

>>> verif/dedup_order_table_core_tb.sv
// ----------------------------------------------------------------------------
// dedup_order_table_core_tb
// self-checking bench for the pending call-order table: adds and deletes go
// in through the input queue while an in-bench copy of the table predicts
// every lamp beat. Results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module dedup_order_table_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dot_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SHOWN_ERRORS = 10;

    // ------------------------------------------------------------------------
    // call table predictor and lamp beat checker
    // ------------------------------------------------------------------------
    class lamp_event_board;
        bit          held [TABLE_DEPTH];
        t_entry      orders [TABLE_DEPTH];
        t_out_beat   lamp_events [$];
        int unsigned mismatches;
        int unsigned beats_seen;

        function new();
            foreach (held[i]) begin
                held[i]   = 1'b0;
                orders[i] = '0;
            end
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function int occupancy();
            int n;
            n = 0;
            foreach (held[i]) if (held[i]) n++;
            return n;
        endfunction

        function int pending();
            return lamp_events.size();
        endfunction

        function t_out_beat make_beat(logic [2:0] kind, logic [1:0] fl, logic [1:0] bt,
                                      logic last);
            t_out_beat b;
            b.kind       = kind;
            b.out_floor  = fl;
            b.out_button = bt;
            b.last       = last;
            return b;
        endfunction

        // update the table for one accepted command and queue its lamp beats
        function void note_command(t_in_beat cmd);
            bit        kept_held [TABLE_DEPTH];
            t_entry    kept [TABLE_DEPTH];
            t_out_beat cleared [TABLE_DEPTH];
            int        n_cleared;
            int        n_kept;
            int        idx;
            logic [1:0] target;

            if (cmd.operation == OP_ADD) begin
                // an exact duplicate is ignored
                foreach (held[i]) begin
                    if (held[i] && orders[i].floor == cmd.floor &&
                        orders[i].button == cmd.button) begin
                        lamp_events.push_back(make_beat(KIND_DUPLICATE, cmd.floor,
                                                        cmd.button, 1'b1));
                        return;
                    end
                end
                // otherwise first free slot, or refuse
                foreach (held[i]) begin
                    if (!held[i]) begin
                        held[i]          = 1'b1;
                        orders[i].floor  = cmd.floor;
                        orders[i].button = cmd.button;
                        lamp_events.push_back(make_beat(KIND_INSERTED, cmd.floor,
                                                        cmd.button, 1'b1));
                        return;
                    end
                end
                lamp_events.push_back(make_beat(KIND_FULL, cmd.floor, cmd.button, 1'b1));
                return;
            end

            idx = int'(cmd.slot_index);
            if (idx >= TABLE_DEPTH) begin
                lamp_events.push_back(make_beat(KIND_BAD_INDEX, 2'd0, 2'd0, 1'b1));
                return;
            end
            if (!held[idx]) begin
                lamp_events.push_back(make_beat(KIND_NOTHING, 2'd0, 2'd0, 1'b1));
                return;
            end

            // named order first, then same floor in position order, rest compacted
            target     = orders[idx].floor;
            n_cleared  = 0;
            n_kept     = 0;
            cleared[0] = make_beat(KIND_REMOVED, target, orders[idx].button, 1'b0);
            n_cleared  = 1;
            foreach (kept_held[i]) begin
                kept_held[i] = 1'b0;
                kept[i]      = '0;
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (held[i] && i != idx) begin
                    if (orders[i].floor == target) begin
                        cleared[n_cleared] = make_beat(KIND_REMOVED, orders[i].floor,
                                                       orders[i].button, 1'b0);
                        n_cleared++;
                    end else begin
                        kept_held[n_kept] = 1'b1;
                        kept[n_kept]      = orders[i];
                        n_kept++;
                    end
                end
            end
            cleared[n_cleared-1].last = 1'b1;
            for (int i = 0; i < n_cleared; i++) lamp_events.push_back(cleared[i]);
            held   = kept_held;
            orders = kept;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) $display("[%0t] %s", $time, what);
        endfunction

        // compare one popped beat with the oldest prediction
        function void check_beat(t_out_beat got);
            t_out_beat want;
            beats_seen++;
            if (lamp_events.size() == 0) begin
                flag($sformatf("beat %0d unexpected: kind=%0d floor=%0d button=%0d last=%0d",
                               beats_seen, got.kind, got.out_floor, got.out_button,
                               got.last));
                return;
            end
            want = lamp_events.pop_front();
            if (got.kind !== want.kind || got.out_floor !== want.out_floor ||
                got.out_button !== want.out_button || got.last !== want.last) begin
                flag($sformatf({"beat %0d wrong: expected kind=%0d floor=%0d button=%0d ",
                                "last=%0d, got kind=%0d floor=%0d button=%0d last=%0d"},
                               beats_seen, want.kind, want.out_floor, want.out_button,
                               want.last, got.kind, got.out_floor, got.out_button,
                               got.last));
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_beat  i_item;
    logic      empty;
    logic      pop;
    t_out_beat o_result;

    lamp_event_board board = new();
    int unsigned     cycles;
    int unsigned     rx_tick;
    int unsigned     rx_mode;

    dedup_order_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // known values from time zero
    initial begin
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        pop     <= 1'b0;
        i_item  <= '0;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: a new random stall pattern is picked each time rx_tick[5:0] reaches 63
    initial begin
        rx_tick = 0;
        rx_mode = 0;
    end
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick[5:0] == 6'd63) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: begin
                pop <= 1'b1;
            end
            1: begin
                pop <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                pop <= (rx_tick[2:0] < 3'd3);
            end
            default: begin
                pop <= ($urandom_range(0, 1) == 1);
            end
        endcase
    end

    // result beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) board.check_beat(o_result);
    end

    function t_in_beat add_order(logic [1:0] fl, logic [1:0] bt);
        t_in_beat b;
        b.operation  = OP_ADD;
        b.floor      = fl;
        b.button     = bt;
        b.slot_index = 4'($urandom_range(0, 15));
        return b;
    endfunction

    function t_in_beat delete_slot(int idx);
        t_in_beat b;
        b.operation  = OP_DEL;
        b.floor      = 2'($urandom_range(0, 3));
        b.button     = 2'($urandom_range(0, 3));
        b.slot_index = 4'(idx);
        return b;
    endfunction

    // random command: mostly adds, deletes mostly aimed at occupied slots
    function t_in_beat random_command();
        int         occ;
        logic [1:0] bt;
        occ = board.occupancy();
        if ($urandom_range(0, 99) < 62) begin
            bt = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            return add_order(2'($urandom_range(0, 3)), bt);
        end
        if (occ > 0 && $urandom_range(0, 99) < 85) return delete_slot($urandom_range(0, occ - 1));
        return delete_slot($urandom_range(0, 15));
    endfunction

    // hold push until the beat is taken
    task automatic drive_beat(t_in_beat b);
        push   <= 1'b1;
        i_item <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_command(b);
    endtask

    task automatic rest(int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int burst;
        int gap;
        int sent;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rest(2);

        // empty table deletes, insert and duplicate
        drive_beat(delete_slot(0));
        drive_beat(delete_slot(15));
        drive_beat(add_order(2'd0, 2'd0));
        drive_beat(add_order(2'd0, 2'd0));
        rest(3);

        // fill every floor and button pair, out-of-range button included
        for (int f = 0; f < 4; f++) begin
            for (int b = 0; b < 4; b++) drive_beat(add_order(2'(f), 2'(b)));
        end
        drive_beat(add_order(2'd2, 2'd2));
        rest(5);

        // floor sweeps from the top and bottom slots, empty slot, middle slot
        drive_beat(delete_slot(15));
        drive_beat(delete_slot(0));
        drive_beat(delete_slot(8));
        drive_beat(delete_slot(5));

        // let the table settle with nothing in flight
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        rest(4);

        // random bursts with random gaps
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                if (sent < RANDOM_ITEMS) begin
                    drive_beat(random_command());
                    sent++;
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) rest(gap);
        end
        push <= 1'b0;

        // drain
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/dot_pkg.sv
hdl/dot_front.sv
hdl/dot_resq.sv
hdl/dot_engine.sv
hdl/dedup_order_table_core.sv
verif/dedup_order_table_core_tb.sv
